// ----- src/ed32_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ed32_pkg: shared types and constants of the signed 32-bit Euclidean divider
// Status codes, pipeline depth and the payload carried by each divide step.
// ----------------------------------------------------------------------------
package ed32_pkg;

	// Operand width and number of restoring steps, one quotient bit per step
	localparam int W         = 32;
	localparam int DIV_STEPS = W;
	// Total latency: magnitude stage, divide steps, correction stage
	localparam int LATENCY   = DIV_STEPS + 2;

	// Saturated quotient for the overflow case
	localparam logic [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// Payload of one divide step
	typedef struct packed {
		logic [W-1:0] rem;    // partial remainder, below ub unless ub is zero
		logic [W-1:0] dq;     // dividend bits still to shift in, quotient bits behind
		logic [W-1:0] ub;     // divisor magnitude
		logic         neg_a;  // dividend negative
		logic         neg_b;  // divisor negative
		logic         div0;   // divisor is zero
		logic         ovf;    // most negative dividend over -1
	} step_t;

endpackage
`default_nettype wire

// ----- src/ed32_div_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ed32_div_step: one registered restoring division step
// Shifts one dividend bit into the partial remainder, trial-subtracts the
// divisor magnitude and shifts the resulting quotient bit in.
// ----------------------------------------------------------------------------
module ed32_div_step
	import ed32_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        en,
	input  wire        in_valid,
	input  wire step_t in_data,
	output logic       out_valid,
	output step_t      out_data
);

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         ge;
	step_t        nxt;
	logic         valid_q;
	step_t        data_q;

	// Trial subtract of the divisor magnitude
	always_comb begin
		trial = {in_data.rem, in_data.dq[W-1]};
		diff  = trial - {1'b0, in_data.ub};
		ge    = ~diff[W];
		nxt   = in_data;
		nxt.rem = ge ? diff[W-1:0] : trial[W-1:0];
		nxt.dq  = {in_data.dq[W-2:0], ge};
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
`default_nettype wire

// ----- src/euclidean_division_32.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// euclidean_division_32: pipelined signed 32-bit Euclidean divider
// Returns quotient and remainder with 0 <= remainder < |divisor|.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per handshake, dividend and divisor in tdata.
//   Output channel m_*: one result item per input item, in order.
//   From acceptance to m_tvalid, one stage forms the operand magnitudes,
//   32 stages each resolve one quotient bit with a 33-bit trial subtract,
//   one stage applies sign and Euclidean correction.
//   Throughput is one item per cycle while the output is not stalled; the 32 divide stages each hold one item.
//   Divide by zero gives quotient 0, remainder 0, status 1. The most
//   negative dividend over -1 gives quotient 2147483647, remainder 0,
//   status 2.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   s_tready drops in the same cycle; nothing is lost or repeated, and
//   s_tready rises again as soon as the result is taken.
// ----------------------------------------------------------------------------
module euclidean_division_32
	import ed32_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,  // [31:0] dividend, [63:32] divisor
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata   // [31:0] quotient, [62:32] remainder, [64:63] status, zero pad
);

	logic         en;
	logic [W-1:0] a;
	logic [W-1:0] b;
	step_t        pre;
	logic         v_s1;
	step_t        d_s1;
	logic         chain_v [0:DIV_STEPS];
	step_t        chain_d [0:DIV_STEPS];
	step_t        fin;
	logic [W-1:0] uq;
	logic [W-1:0] ur;
	logic         corr;
	logic [W-1:0] q_c;
	logic [W-1:0] r_c;
	status_t      st_c;
	logic         v_s34;
	logic [W-1:0] q_s34;
	logic [W-2:0] r_s34;
	status_t      st_s34;

	// Global advance: move when the output slot is empty or being taken
	assign en       = ~v_s34 | m_tready;
	assign s_tready = en;

	// Stage 1: operand magnitudes and special-case flags
	always_comb begin
		a         = s_tdata[W-1:0];
		b         = s_tdata[2*W-1:W];
		pre.rem   = '0;
		pre.dq    = a[W-1] ? (~a + 1'b1) : a;
		pre.ub    = b[W-1] ? (~b + 1'b1) : b;
		pre.neg_a = a[W-1];
		pre.neg_b = b[W-1];
		pre.div0  = (b == '0);
		pre.ovf   = (a == {1'b1, {(W-1){1'b0}}}) && (b == '1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= pre;
		end
	end

	// Divide stages, one quotient bit each
	assign chain_v[0] = v_s1;
	assign chain_d[0] = d_s1;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		ed32_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_v[i]),
			.in_data   (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_data  (chain_d[i+1])
		);
	end

	// Final stage: sign, Euclidean correction, special cases
	always_comb begin
		fin  = chain_d[DIV_STEPS];
		uq   = fin.dq;
		ur   = fin.rem;
		// truncated remainder negative needs correction
		corr = fin.neg_a && (ur != '0);
		if (fin.neg_a ^ fin.neg_b) begin
			// negative quotient; correction means divisor positive: -uq - 1
			q_c = corr ? ~uq : (~uq + 1'b1);
		end else begin
			// nonnegative quotient; correction means divisor negative: uq + 1
			q_c = corr ? (uq + 1'b1) : uq;
		end
		r_c  = corr ? (fin.ub - ur) : ur;
		st_c = ST_OK;
		if (fin.div0) begin
			q_c  = '0;
			r_c  = '0;
			st_c = ST_DIV0;
		end else if (fin.ovf) begin
			q_c  = Q_MAX;
			r_c  = '0;
			st_c = ST_OVF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s34 <= 1'b0;
		end else if (en) begin
			v_s34 <= chain_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s34  <= q_c;
			r_s34  <= r_c[W-2:0];
			st_s34 <= st_c;
		end
	end

	assign m_tvalid = v_s34;
	assign m_tdata  = {7'd0, st_s34, r_s34, q_s34};

`ifndef NO_ASSERTIONS
	// A stalled pipeline keeps the valid bits of stage 1 and of the last divide stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(chain_v[DIV_STEPS])))
		else $error("pipeline valid bits moved during stall");

	// Divide by zero yields all-zero quotient and remainder
	a_div0: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && st_s34 == ST_DIV0) |-> (q_s34 == '0 && r_s34 == '0))
		else $error("divide by zero result not cleared");

	// Overflow result is saturated
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && st_s34 == ST_OVF) |-> (q_s34 == Q_MAX && r_s34 == '0))
		else $error("overflow result not saturated");
`endif

endmodule
`default_nettype wire
